// ----- hw/rtl/drrip_pkg.sv -----
// ----------------------------------------------------------------------------
// DRRIP package
// Shared codes, field widths and a helper function for the DRRIP replacement
// policy block.
// ----------------------------------------------------------------------------
`default_nettype none

package drrip_pkg;

   // Fixed widths of the word fields
   localparam int OPCODE_W  = 1;
   localparam int SET_IDX_W = 11;
   localparam int WAY_IN_W  = 4;
   localparam int MASK_W    = 16;
   localparam int VICTIM_W  = 4;
   localparam int SEL_OUT_W = 10;
   localparam int SEED_W    = 16;

   // Operation codes
   localparam logic OP_VICTIM = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   // Re-reference values
   typedef logic [1:0] rrpv_type;
   localparam rrpv_type RRPV_NEAR    = 2'd0;
   localparam rrpv_type RRPV_LONG    = 2'd2;
   localparam rrpv_type RRPV_DISTANT = 2'd3;

   // Set classification for set dueling
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_STATIC  = 2'd0;
   localparam kind_type KIND_BIMODAL = 2'd1;
   localparam kind_type KIND_FOLLOW  = 2'd2;

   // Bimodal draw: Galois LFSR, near insertion when the low bits are all zero
   localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;
   localparam logic [SEED_W-1:0] LFSR_ONE  = 16'h0001;
   localparam int                BIP_W     = 5;

   function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] x);
      logic [SEED_W-1:0] sh;
      sh = x >> 1;
      return x[0] ? (sh ^ LFSR_TAPS) : sh;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/drrip_req_if.sv -----
// ----------------------------------------------------------------------------
// DRRIP request channel
// Valid/ready channel that carries one victim or update request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface drrip_req_if import drrip_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [SET_IDX_W-1:0] set_index;
   logic [WAY_IN_W-1:0]  way;
   logic                 hit;
   logic [MASK_W-1:0]    valid_mask;

   modport source (output valid, opcode, set_index, way, hit, valid_mask,
                   input ready);
   modport sink   (input valid, opcode, set_index, way, hit, valid_mask,
                   output ready);

endinterface

`default_nettype wire

// ----- hw/rtl/drrip_rsp_if.sv -----
// ----------------------------------------------------------------------------
// DRRIP response channel
// Valid/ready channel that carries one result word per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface drrip_rsp_if import drrip_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [VICTIM_W-1:0]  victim_way;
   logic [SEL_OUT_W-1:0] selector_value;

   modport source (output valid, victim_way, selector_value, input ready);
   modport sink   (input valid, victim_way, selector_value, output ready);

endinterface

`default_nettype wire

// ----- hw/rtl/drrip_rrmem.sv -----
// ----------------------------------------------------------------------------
// DRRIP re-reference memory
// One row per set, 2 bits per way; single write port, registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module drrip_rrmem #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11,
   parameter int ROW_W  = 32
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [ROW_W-1:0]  rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [ROW_W-1:0]  wr_data
);

   logic [ROW_W-1:0] mem_ff [DEPTH];
   logic [ROW_W-1:0] rd_data_ff;

   // Write one row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read one row, hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/drrip_kind.sv -----
// ----------------------------------------------------------------------------
// DRRIP set classifier
// Three-stage pipeline that tells static leaders, bimodal leaders and
// followers apart. Leader i sits at set floor(i*SETS/LEADERS); the unit
// forms i = ceil(s*LEADERS/SETS) by a reciprocal multiply with one
// correction step and checks that leader i lands on set s.
// ----------------------------------------------------------------------------
`default_nettype none

module drrip_kind import drrip_pkg::*; #(
   parameter int SETS    = 2048,
   parameter int LEADERS = 64,
   parameter int SET_W   = 11
) (
   input  wire logic             clock,
   input  wire logic [SET_W-1:0] set_idx,
   output kind_type              kind
);

   localparam int LDR_W = $clog2(LEADERS + 1);
   localparam int T_W   = SET_W + LDR_W;
   localparam int Y_W   = T_W + 1;
   localparam int K_SH  = Y_W;
   localparam longint unsigned RECIP = (64'd1 << K_SH) / SETS;
   localparam int R_W   = $clog2(RECIP + 1);
   localparam int P_W   = Y_W + R_W;
   localparam int Q_W   = LDR_W + 1;

   logic [T_W-1:0] prod_sl_ff;
   logic [Y_W-1:0] num_ff;
   logic [P_W-1:0] prod_q_ff;
   kind_type       kind_ff;

   logic [Y_W-1:0] num;
   logic [Q_W-1:0] quo_est;
   logic [Y_W-1:0] quo_set;
   logic [Y_W-1:0] rem_est;
   logic [Q_W-1:0] quo;
   logic [Y_W-1:0] rem;
   kind_type       kind_in;

   // Stage 1: s * LEADERS
   always_ff @(posedge clock) begin
      prod_sl_ff <= T_W'(set_idx) * T_W'(LEADERS);
   end

   // Stage 2: numerator for the ceiling, times the reciprocal of SETS
   assign num = Y_W'(prod_sl_ff) + Y_W'(SETS - 1);

   always_ff @(posedge clock) begin
      num_ff    <= num;
      prod_q_ff <= P_W'(num) * P_W'(RECIP);
   end

   // Stage 3: correct the quotient estimate and classify
   always_comb begin
      quo_est = Q_W'(prod_q_ff >> K_SH);
      quo_set = Y_W'(quo_est) * Y_W'(SETS);
      rem_est = num_ff - quo_set;
      if (rem_est >= Y_W'(SETS)) begin
         quo = quo_est + Q_W'(1);
         rem = rem_est - Y_W'(SETS);
      end else begin
         quo = quo_est;
         rem = rem_est;
      end
      if ((quo >= Q_W'(LEADERS)) || ((rem + Y_W'(LEADERS)) < Y_W'(SETS))) begin
         kind_in = KIND_FOLLOW;
      end else if (quo < Q_W'(LEADERS / 2)) begin
         kind_in = KIND_STATIC;
      end else begin
         kind_in = KIND_BIMODAL;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/drrip_replacement_policy_top.sv -----
// ----------------------------------------------------------------------------
// DRRIP replacement policy
// Set-dueling DRRIP: per-set re-reference values in a memory, a shared
// saturating policy selector and an LFSR for bimodal insertion.
// ----------------------------------------------------------------------------
// An item goes from acceptance to a registered result in these steps: accept,
// read of the set row from the re-reference memory, the multiply and check
// states in which the leader-set classifier finishes its multiplies, and the
// write-back state that updates the row, the selector and the LFSR. Write-back
// waits while the output register holds a result not yet taken. The block
// works on one item at a time: the memory read, the three-stage set classifier
// that runs beside it and the write-back of the row all lie between acceptance
// and the next acceptance. The result sits in an output register, so the next
// item is taken while a result still waits. After reset a clearing pass writes
// every row of the memory, one row a cycle; no item is accepted until it ends,
// while seed writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module drrip_replacement_policy_top import drrip_pkg::*; #(
   parameter int SETS          = 2048,
   parameter int WAYS          = 16,
   parameter int LEADERS       = 64,
   parameter int SELECTOR_BITS = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [SEED_W-1:0] csr_wr_data,
   drrip_req_if.sink              req_chan,
   drrip_rsp_if.source            rsp_chan
);

   localparam int SET_W  = $clog2(SETS);
   localparam int WAY_W  = $clog2(WAYS);
   localparam int ROW_W  = 2 * WAYS;
   localparam int MASK_N = (WAYS < MASK_W) ? WAYS : MASK_W;
   localparam int SB     = SELECTOR_BITS;
   localparam logic [SB-1:0]    SEL_MAX  = {SB{1'b1}};
   localparam logic [SB-1:0]    SEL_MID  = SB'(1) << (SB - 1);
   localparam logic [ROW_W-1:0] INIT_ROW = {WAYS{RRPV_LONG}};

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_MULT  = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [SET_W-1:0]    clr_ff, clr_in;
   logic [SET_W-1:0]    set_ff;
   logic [WAY_W-1:0]    way_ff;
   logic                op_ff;
   logic                hit_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic [SB-1:0]       selector_ff, selector_in;
   logic [SEED_W-1:0]   lfsr_ff, lfsr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VICTIM_W-1:0] rsp_victim_ff;
   logic [SEL_OUT_W-1:0] rsp_sel_ff;

   logic                req_take;
   logic                write_go;
   logic [SET_IDX_W-1:0] set_red;
   logic [WAY_IN_W-1:0] way_red;

   logic                mem_rd_en;
   logic [ROW_W-1:0]    rd_row;
   logic                mem_wr_en;
   logic [SET_W-1:0]    mem_wr_addr;
   logic [ROW_W-1:0]    mem_wr_data;

   kind_type            kind;

   logic                found_inv;
   logic [WAY_W-1:0]    inv_way;
   logic                found_far;
   logic [WAY_W-1:0]    far_way;
   logic [WAY_W-1:0]    victim_way;
   logic                age_needed;
   logic [ROW_W-1:0]    aged_row;

   logic                draw_needed;
   logic [SEED_W-1:0]   lfsr_next;
   rrpv_type            ins_val;
   logic [ROW_W-1:0]    upd_row;

   // Handshake
   assign req_take       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign write_go       = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_chan.ready);

   // Fold the set and way into range by repeated compare and subtract
   always_comb begin
      set_red = req_chan.set_index;
      for (int k = 4; k >= 0; k--) begin
         if (32'(set_red) >= (32'(SETS) << k)) begin
            set_red = set_red - SET_IDX_W'(32'(SETS) << k);
         end
      end
      way_red = req_chan.way;
      for (int k = 2; k >= 0; k--) begin
         if (32'(way_red) >= (32'(WAYS) << k)) begin
            way_red = way_red - WAY_IN_W'(32'(WAYS) << k);
         end
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (req_take) begin
         set_ff  <= SET_W'(set_red);
         way_ff  <= WAY_W'(way_red);
         op_ff   <= req_chan.opcode;
         hit_ff  <= req_chan.hit;
         mask_ff <= req_chan.valid_mask;
      end
   end

   // Clearing pass after reset, then one item at a time through read, classify and write-back
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_MULT;
         ST_MULT:  state_in = ST_CHECK;
         ST_CHECK: state_in = ST_WRITE;
         ST_WRITE: begin
            if (write_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Victim search over the row read back
   always_comb begin
      found_inv = 1'b0;
      inv_way   = '0;
      for (int w = 0; w < MASK_N; w++) begin
         if (!found_inv && !mask_ff[w]) begin
            found_inv = 1'b1;
            inv_way   = WAY_W'(w);
         end
      end
      found_far = 1'b0;
      far_way   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (rd_row[2*w +: 2] == RRPV_DISTANT) begin
            found_far = 1'b1;
            far_way   = WAY_W'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (rd_row[2*w +: 2] == RRPV_DISTANT) begin
            aged_row[2*w +: 2] = RRPV_DISTANT;
         end else begin
            aged_row[2*w +: 2] = rd_row[2*w +: 2] + 2'd1;
         end
      end
      age_needed = !found_inv && !found_far;
      if (found_inv) begin
         victim_way = inv_way;
      end else if (found_far) begin
         victim_way = far_way;
      end else begin
         victim_way = WAY_W'(WAYS - 1);
      end
   end

   // Insertion value, selector update and LFSR update
   always_comb begin
      draw_needed = (kind == KIND_BIMODAL) ||
                    ((kind == KIND_FOLLOW) && (selector_ff < SEL_MID));
      lfsr_next   = lfsr_step(lfsr_ff);
      if (draw_needed && (lfsr_next[BIP_W-1:0] == '0)) begin
         ins_val = RRPV_NEAR;
      end else begin
         ins_val = RRPV_LONG;
      end
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == way_ff) begin
            upd_row[2*w +: 2] = ins_val;
         end else begin
            upd_row[2*w +: 2] = rd_row[2*w +: 2];
         end
      end
      selector_in = selector_ff;
      if ((op_ff == OP_UPDATE) && !hit_ff) begin
         if ((kind == KIND_STATIC) && (selector_ff != SEL_MAX)) begin
            selector_in = selector_ff + SB'(1);
         end else if ((kind == KIND_BIMODAL) && (selector_ff != '0)) begin
            selector_in = selector_ff - SB'(1);
         end
      end
      lfsr_in = lfsr_ff;
      if (csr_wr_en) begin
         lfsr_in = (csr_wr_data == '0) ? LFSR_ONE : csr_wr_data;
      end else if (write_go && (op_ff == OP_UPDATE) && draw_needed) begin
         lfsr_in = lfsr_next;
      end
   end

   // Policy state
   always_ff @(posedge clock) begin
      if (reset) begin
         selector_ff <= SEL_MID;
         lfsr_ff     <= LFSR_ONE;
      end else begin
         if (write_go) begin
            selector_ff <= selector_in;
         end
         lfsr_ff <= lfsr_in;
      end
   end

   // Memory access: clearing pass, or write-back of the item's row
   always_comb begin
      mem_rd_en   = (state_ff == ST_READ);
      mem_wr_en   = 1'b0;
      mem_wr_addr = set_ff;
      mem_wr_data = upd_row;
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_ff;
         mem_wr_data = INIT_ROW;
      end else if (write_go) begin
         if (op_ff == OP_UPDATE) begin
            mem_wr_en   = 1'b1;
            mem_wr_data = upd_row;
         end else if (age_needed) begin
            mem_wr_en   = 1'b1;
            mem_wr_data = aged_row;
         end
      end
   end

   drrip_rrmem #(
      .DEPTH  (SETS),
      .ADDR_W (SET_W),
      .ROW_W  (ROW_W)
   ) u_rrmem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (set_ff),
      .rd_data (rd_row),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   drrip_kind #(
      .SETS    (SETS),
      .LEADERS (LEADERS),
      .SET_W   (SET_W)
   ) u_kind (
      .clock   (clock),
      .set_idx (set_ff),
      .kind    (kind)
   );

   // Output register: hold the word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (write_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_go) begin
         rsp_victim_ff <= (op_ff == OP_UPDATE) ? '0 : VICTIM_W'(victim_way);
         rsp_sel_ff    <= SEL_OUT_W'(selector_in);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.victim_way     = rsp_victim_ff;
   assign rsp_chan.selector_value = rsp_sel_ff;

   // A new result only comes out of the write-back cycle
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_WRITE))
      else $error("result raised outside write-back");

   // The selector moves only on a missed update in write-back
   a_sel_moves: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (selector_ff != $past(selector_ff))) |->
      (($past(state_ff) == ST_WRITE) && !$past(hit_ff) && ($past(op_ff) == OP_UPDATE)))
      else $error("selector changed without a missed update");

   // The LFSR never locks up at zero
   a_lfsr_live: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("LFSR reached zero");

   // An update word always reports way zero
   a_update_way: assert property (@(posedge clock) disable iff (reset)
      $past(write_go && (op_ff == OP_UPDATE)) |-> (rsp_victim_ff == '0))
      else $error("update returned a nonzero way");

endmodule

`default_nettype wire

// ----- sim/drrip_replacement_policy_top_test.sv -----
// ----------------------------------------------------------------------------
// DRRIP replacement policy testbench
// Drives victim and update words into the block and checks every result word
// against a behavioral copy of the set-dueling policy. Directed words hit the
// field extremes and the corner cases (first invalid way, distant way, aging,
// leader sets and follower sets, ignored fields). Random words follow, under
// several seeds, with a sweep that pins the selector at its floor. The
// receiver holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module drrip_replacement_policy_top_test;
   import drrip_pkg::*;

   localparam int SETS          = 2048;
   localparam int WAYS          = 16;
   localparam int LEADERS       = 64;
   localparam int SELECTOR_BITS = 10;

   localparam logic [SELECTOR_BITS-1:0] SEL_TOP = '1;
   localparam logic [SELECTOR_BITS-1:0] SEL_MID = SELECTOR_BITS'(1) << (SELECTOR_BITS - 1);

   // Clearing pass after reset plus the long hold-off fit well inside this
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_PCT    = 18;
   localparam int MAX_REPORTS = 40;
   localparam int SETTLE      = 8;

   typedef struct packed {
      logic [OPCODE_W-1:0]  opcode;
      logic [SET_IDX_W-1:0] set_index;
      logic [WAY_IN_W-1:0]  way;
      logic                 hit;
      logic [MASK_W-1:0]    valid_mask;
   } access_word_type;

   typedef struct packed {
      logic [VICTIM_W-1:0]  victim_way;
      logic [SEL_OUT_W-1:0] selector_value;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_we_q   = 1'b0;
   logic [SEED_W-1:0] csr_data_q = '0;

   logic            req_valid_q = 1'b0;
   access_word_type req_word_q  = '0;
   logic            rsp_ready_q = 1'b0;

   drrip_req_if req_bus ();
   drrip_rsp_if rsp_bus ();

   assign req_bus.valid      = req_valid_q;
   assign req_bus.opcode     = req_word_q.opcode;
   assign req_bus.set_index  = req_word_q.set_index;
   assign req_bus.way        = req_word_q.way;
   assign req_bus.hit        = req_word_q.hit;
   assign req_bus.valid_mask = req_word_q.valid_mask;
   assign rsp_bus.ready      = rsp_ready_q;

   drrip_replacement_policy_top #(
      .SETS          (SETS),
      .WAYS          (WAYS),
      .LEADERS       (LEADERS),
      .SELECTOR_BITS (SELECTOR_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_we_q),
      .csr_wr_data (csr_data_q),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   always #1 clock = ~clock;

   // Shadow of the policy state
   rrpv_type                 rrpv_shadow [SETS][WAYS];
   logic [SELECTOR_BITS-1:0] psel_shadow;
   logic [SEED_W-1:0]        lfsr_shadow;

   access_word_type pending_words[$];
   result_word_type expected_results[$];

   logic req_taken  = 1'b0;
   logic no_idle    = 1'b0;
   int   hold_asked = 0;
   int   hold_done  = 0;
   int   hold_left  = 0;
   int   idle_cycles = 0;

   int errors        = 0;
   int words_taken   = 0;
   int results_seen  = 0;
   int aging_passes  = 0;
   int near_inserts  = 0;
   int pinned_top    = 0;
   int pinned_floor  = 0;
   int seeds_written = 0;

   // Leader i sits at set floor(i*SETS/LEADERS); lower half static, upper bimodal
   function automatic kind_type classify_set(input int unsigned s);
      longint unsigned i;
      i = (64'(s) * LEADERS + SETS - 1) / SETS;
      if (i >= LEADERS)
         return KIND_FOLLOW;
      if ((i * SETS) / LEADERS != s)
         return KIND_FOLLOW;
      return (i < LEADERS / 2) ? KIND_STATIC : KIND_BIMODAL;
   endfunction

   // Advance the Galois LFSR one step; near insertion when the low bits are zero
   function automatic rrpv_type draw_insertion();
      logic [SEED_W-1:0] x;
      x = lfsr_shadow >> 1;
      if (lfsr_shadow[0])
         x = x ^ LFSR_TAPS;
      lfsr_shadow = x;
      if (x[BIP_W-1:0] == '0) begin
         near_inserts++;
         return RRPV_NEAR;
      end
      return RRPV_LONG;
   endfunction

   // Append a word to the send queue
   task automatic stage_word(input access_word_type a);
      pending_words.insert(pending_words.size(), a);
   endtask

   // Work out the result of one accepted word and queue it
   task automatic predict_access(input access_word_type a);
      int unsigned     s;
      int unsigned     w;
      int unsigned     victim;
      logic            found;
      kind_type        k;
      rrpv_type        ins;
      result_word_type r;
      s      = a.set_index % SETS;
      w      = a.way % WAYS;
      victim = 0;
      found  = 1'b0;
      if (a.opcode == OP_VICTIM) begin
         for (int i = 0; i < WAYS && i < MASK_W; i++) begin
            if (!found && !a.valid_mask[i]) begin
               victim = i;
               found  = 1'b1;
            end
         end
         // highest-numbered distant way wins
         if (!found) begin
            for (int i = 0; i < WAYS; i++) begin
               if (rrpv_shadow[s][i] == RRPV_DISTANT) begin
                  victim = i;
                  found  = 1'b1;
               end
            end
         end
         if (!found) begin
            for (int i = 0; i < WAYS; i++) begin
               if (rrpv_shadow[s][i] != RRPV_DISTANT)
                  rrpv_shadow[s][i] = rrpv_shadow[s][i] + 2'd1;
            end
            victim = WAYS - 1;
            aging_passes++;
         end
      end else begin
         k = classify_set(s);
         if (k == KIND_STATIC)
            ins = RRPV_LONG;
         else if (k == KIND_BIMODAL)
            ins = draw_insertion();
         else if (psel_shadow >= SEL_MID)
            ins = RRPV_LONG;
         else
            ins = draw_insertion();
         rrpv_shadow[s][w] = ins;
         if (!a.hit) begin
            if (k == KIND_STATIC) begin
               if (psel_shadow != SEL_TOP)
                  psel_shadow = psel_shadow + 1'b1;
               else
                  pinned_top++;
            end else if (k == KIND_BIMODAL) begin
               if (psel_shadow != '0)
                  psel_shadow = psel_shadow - 1'b1;
               else
                  pinned_floor++;
            end
         end
      end
      r.victim_way     = VICTIM_W'(victim);
      r.selector_value = SEL_OUT_W'(psel_shadow);
      expected_results.insert(expected_results.size(), r);
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("mismatch on result %0d: %s got %0d expected %0d",
                  results_seen, what, got, want);
   endtask

   // Sample both channels, check results, predict accepted words, watch for hangs
   always @(posedge clock) begin
      access_word_type seen;
      result_word_type got;
      result_word_type want;
      logic            rsp_taken;
      if (reset) begin
         req_taken   = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_bus.valid && req_bus.ready;
         rsp_taken = rsp_bus.valid && rsp_bus.ready;
         if (rsp_taken) begin
            results_seen++;
            got.victim_way     = rsp_bus.victim_way;
            got.selector_value = rsp_bus.selector_value;
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing outstanding, victim_way",
                               got.victim_way, 0);
            end else begin
               want = expected_results.pop_front();
               if (got.victim_way !== want.victim_way)
                  report_mismatch("victim_way", got.victim_way, want.victim_way);
               if (got.selector_value !== want.selector_value)
                  report_mismatch("selector_value", got.selector_value,
                                  want.selector_value);
            end
         end
         if (req_taken) begin
            words_taken++;
            seen.opcode     = req_bus.opcode;
            seen.set_index  = req_bus.set_index;
            seen.way        = req_bus.way;
            seen.hit        = req_bus.hit;
            seen.valid_mask = req_bus.valid_mask;
            predict_access(seen);
         end
         if (req_taken || rsp_taken)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_results.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Feed words from the pending queue, idling at random
   always @(negedge clock) begin
      logic offer;
      if (!reset && (!req_valid_q || req_taken)) begin
         offer = (pending_words.size() > 0) &&
                 (no_idle || ($urandom_range(99) >= IDLE_PCT));
         if (offer) begin
            req_word_q  <= pending_words.pop_front();
            req_valid_q <= 1'b1;
         end else begin
            req_valid_q <= 1'b0;
         end
      end
   end

   // Accept results, idling at random; hold off for a long stretch on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready_q <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready_q <= 1'b0;
         hold_left--;
      end else if (hold_asked != hold_done) begin
         hold_done = hold_asked;
         hold_left = HOLD_CYCLES;
         rsp_ready_q <= 1'b0;
      end else begin
         rsp_ready_q <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   function automatic access_word_type make_word(input logic op, input int unsigned s,
                                                 input int unsigned w, input logic h,
                                                 input logic [MASK_W-1:0] m);
      access_word_type a;
      a.opcode     = op;
      a.set_index  = SET_IDX_W'(s);
      a.way        = WAY_IN_W'(w);
      a.hit        = h;
      a.valid_mask = m;
      return a;
   endfunction

   // Mostly full sets, so the distant-way search and aging get exercised
   function automatic logic [MASK_W-1:0] random_mask();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70)
         return '1;
      if (r < 85)
         return ~(MASK_W'(1) << $urandom_range(MASK_W - 1));
      return MASK_W'($urandom);
   endfunction

   // One cache access: a hit, or a victim choice followed by the fill; some noise
   task automatic queue_access(input int unsigned s);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35) begin
         stage_word(make_word(OP_UPDATE, s, $urandom_range(15), 1'b1,
                              MASK_W'($urandom)));
      end else if (r < 90) begin
         stage_word(make_word(OP_VICTIM, s, $urandom_range(15),
                              1'($urandom_range(1)), random_mask()));
         stage_word(make_word(OP_UPDATE, s, $urandom_range(15), 1'b0,
                              MASK_W'($urandom)));
      end else if (r < 95) begin
         stage_word(make_word(OP_VICTIM, $urandom_range(2047),
                              $urandom_range(15), 1'($urandom_range(1)), '1));
      end else begin
         stage_word(make_word(OP_UPDATE, $urandom_range(2047),
                              $urandom_range(15), 1'b0, MASK_W'($urandom)));
      end
   endtask

   // Accesses over a small pool of sets so rows build up, with some spread
   task automatic queue_mixed(input int count);
      int unsigned pool [8];
      pool[0] = $urandom_range(31) * 32;
      pool[1] = (32 + $urandom_range(31)) * 32;
      pool[2] = 2047;
      for (int i = 3; i < 8; i++)
         pool[i] = $urandom_range(2047);
      while (pending_words.size() < count) begin
         if ($urandom_range(99) < 80)
            queue_access(pool[$urandom_range(7)]);
         else
            queue_access($urandom_range(2047));
      end
   endtask

   // Misses into one kind of leader set, to drive the selector to a limit
   task automatic queue_sweep(input logic to_floor, input int misses);
      int          m;
      int unsigned s;
      m = 0;
      while (m < misses) begin
         s = (to_floor ? 32 + $urandom_range(31) : $urandom_range(31)) * 32;
         if ($urandom_range(99) < 90) begin
            stage_word(make_word(OP_UPDATE, s, $urandom_range(15), 1'b0,
                                 MASK_W'($urandom)));
            m++;
         end else if ($urandom_range(1) == 0) begin
            queue_access(s);
         end else begin
            queue_access($urandom_range(2047));
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || req_valid_q || expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_seed(input logic [SEED_W-1:0] v);
      @(negedge clock);
      csr_we_q   <= 1'b1;
      csr_data_q <= v;
      lfsr_shadow = (v == '0) ? LFSR_ONE : v;
      seeds_written++;
      @(negedge clock);
      csr_we_q <= 1'b0;
   endtask

   initial begin
      // Reset state of the shadow copy
      for (int s = 0; s < SETS; s++)
         for (int w = 0; w < WAYS; w++)
            rrpv_shadow[s][w] = RRPV_LONG;
      psel_shadow = SEL_MID;
      lfsr_shadow = LFSR_ONE;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: mask extremes, aging, distant way, leaders, followers
      stage_word(make_word(OP_VICTIM, 0, 0, 1'b0, 16'h0000));
      stage_word(make_word(OP_VICTIM, 0, 0, 1'b0, 16'hFFFE));
      stage_word(make_word(OP_VICTIM, 0, 0, 1'b0, 16'h7FFF));
      stage_word(make_word(OP_VICTIM, 0, 0, 1'b0, 16'hFFFF));
      stage_word(make_word(OP_VICTIM, 0, 0, 1'b0, 16'hFFFF));
      stage_word(make_word(OP_UPDATE, 0, 15, 1'b0, 16'h0000));
      stage_word(make_word(OP_VICTIM, 0, 0, 1'b0, 16'hFFFF));
      stage_word(make_word(OP_UPDATE, 0, 14, 1'b1, 16'h0000));
      stage_word(make_word(OP_UPDATE, 992, 0, 1'b0, 16'h0000));
      stage_word(make_word(OP_UPDATE, 1024, 3, 1'b0, 16'h0000));
      stage_word(make_word(OP_UPDATE, 2016, 15, 1'b1, 16'h0000));
      stage_word(make_word(OP_UPDATE, 2047, 15, 1'b0, 16'h0000));
      stage_word(make_word(OP_VICTIM, 2047, 0, 1'b0, 16'hFFFF));
      stage_word(make_word(OP_VICTIM, 2047, 0, 1'b0, 16'h8000));
      stage_word(make_word(OP_VICTIM, 2047, 0, 1'b0, 16'hBFFF));
      stage_word(make_word(OP_UPDATE, 5, 0, 1'b1, 16'h0000));
      stage_word(make_word(OP_VICTIM, 1024, 0, 1'b0, 16'hFFFF));
      stage_word(make_word(OP_UPDATE, 31, 7, 1'b0, 16'h0000));
      stage_word(make_word(OP_UPDATE, 33, 8, 1'b0, 16'h0000));
      stage_word(make_word(OP_VICTIM, 1023, 0, 1'b0, 16'hFFFF));
      // ignored fields set on both operations
      stage_word(make_word(OP_VICTIM, 0, 15, 1'b1, 16'hFFFF));
      stage_word(make_word(OP_UPDATE, 1056, 9, 1'b0, 16'hFFFF));
      wait_idle();

      // Zero seed, mixed traffic, receiver backs up the block early on
      write_seed('0);
      queue_mixed(120);
      hold_asked++;
      wait_idle();

      // Random seed, no idling, selector driven to zero, followers go bimodal
      write_seed(SEED_W'($urandom_range(65535, 1)));
      no_idle = 1'b1;
      queue_sweep(1'b1, 560);
      wait_idle();
      no_idle = 1'b0;

      // Top seed, mixed traffic with the selector low
      write_seed('1);
      queue_mixed(30);
      wait_idle();

      // Lowest nonzero seed, mixed traffic
      write_seed(LFSR_ONE);
      queue_mixed(30);
      wait_idle();

      $display("covered %0d request words and %0d result words under %0d seed settings",
               words_taken, results_seen, seeds_written);
      $display("aging passes %0d, near insertions %0d, selector pinned high %0d low %0d",
               aging_passes, near_inserts, pinned_top, pinned_floor);
      if (errors == 0 && expected_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
